### rtl/pnr_pkg.sv
package pnr_pkg;

  localparam int LIGHT_BITS   = 8;
  localparam int LEVEL_BITS   = 8;
  localparam int NUM_LIGHTS   = 3;
  localparam int DIV_STEPS    = LEVEL_BITS;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [LIGHT_BITS-1:0] light_t;
  typedef logic [LEVEL_BITS-1:0] level_t;

  localparam level_t LEVEL_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_reg_t;

  // reset adjugate rows, coefficient 0 first
  localparam int ROW_X_C0 = 2;
  localparam int ROW_X_C1 = -2;
  localparam int ROW_X_C2 = 0;
  localparam int ROW_Y_C0 = 1;
  localparam int ROW_Y_C1 = 1;
  localparam int ROW_Y_C2 = -2;
  localparam int ROW_Z_C0 = 1;
  localparam int ROW_Z_C1 = 1;
  localparam int ROW_Z_C2 = 2;

endpackage

### rtl/pnr_ratio_div.sv
module pnr_ratio_div #(
  parameter int NW = 27
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic signed [NW-1:0]  num,
  input  logic signed [NW-1:0]  den,
  output pnr_pkg::level_t       level
);

  localparam int RW = NW + pnr_pkg::LEVEL_BITS;
  localparam int DW = NW + 1;
  localparam int NS = pnr_pkg::DIV_STEPS;

  logic [RW-1:0]  rem  [NS+1];
  logic [NW-1:0]  dmag [NS+1];
  pnr_pkg::level_t quo [NS+1];
  logic [NS:0]    kill;
  logic [NS:0]    sat;

  logic signed [RW-1:0] num_x;
  logic [RW-1:0]        a_mag;
  logic signed [DW-1:0] den_x;
  logic [NW-1:0]        d_mag;
  logic                 kill0;
  logic                 sat0;

  // 255*num = 256*num - num
  always_comb begin
    num_x = $signed({num, {pnr_pkg::LEVEL_BITS{1'b0}}}) - RW'(num);
    a_mag = num_x[RW-1] ? RW'(-num_x) : RW'(num_x);
    den_x = DW'(den);
    d_mag = den_x[DW-1] ? NW'(-den_x) : NW'(den_x);
    kill0 = (den == '0) || (num == '0) || (num[NW-1] != den[NW-1]);
    sat0  = a_mag >= (RW'(d_mag) << pnr_pkg::LEVEL_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kill[0] <= 1'b1;
    end else if (en) begin
      kill[0] <= kill0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= a_mag;
      dmag[0] <= d_mag;
      quo[0]  <= '0;
      sat[0]  <= sat0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int SH = NS - 1 - k;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(dmag[k]) << SH;
    assign take = rem[k] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        kill[k+1] <= 1'b1;
      end else if (en) begin
        kill[k+1] <= kill[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - dsh : rem[k];
        dmag[k+1] <= dmag[k];
        quo[k+1]  <= {quo[k][pnr_pkg::LEVEL_BITS-2:0], take};
        sat[k+1]  <= sat[k];
      end
    end
  end

  assign level = kill[NS] ? '0 : (sat[NS] ? pnr_pkg::LEVEL_MAX : quo[NS]);

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    !kill[NS] && !sat[NS] |-> rem[NS] < RW'(dmag[NS]))
    else $error("final remainder not below divisor");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    !kill[0] && !sat[0] |-> rem[0] < (RW'(dmag[0]) << pnr_pkg::LEVEL_BITS))
    else $error("unsaturated quotient exceeds level range");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(level))
    else $error("level moved during stall");

endmodule

### rtl/photometric_normal_ratio_pixel_top.sv
// channel  dir  signals                              fields (low bit up)
// s        in   s_tvalid s_tready s_tdata[23:0]      level_light_a, _b, _c
// m        out  m_tvalid m_tready m_tdata[15:0]      red_level, green_level
// cfg      in   cfg_valid cfg_ready cfg_index cfg_data  row_x/y/z coeffs
//
// One pixel per cycle while the result is not stalled; registered steps: products, sums, divider setup,
// then one quotient bit per stage in each of two 8-stage restoring dividers.
// Synchronous reset clears valid bits and loads the default coefficient rows.
// A stalled result holds the whole pipeline; no request is lost or repeated.
// Config writes are always accepted and take effect on the next request.
module photometric_normal_ratio_pixel_top #(
  parameter int COEF_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata, // level_light_a, level_light_b, level_light_c
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata, // red_level, green_level
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pnr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [3*COEF_BITS-1:0]           cfg_data
);

  localparam int RW  = 3 * COEF_BITS;
  localparam int PW  = COEF_BITS + pnr_pkg::LIGHT_BITS + 1;
  localparam int NW  = PW + 2;
  localparam int NL  = pnr_pkg::NUM_LIGHTS;
  localparam int LAT = 3 + pnr_pkg::DIV_STEPS;

  localparam logic [RW-1:0] ROW_X_INIT = {COEF_BITS'(pnr_pkg::ROW_X_C2),
    COEF_BITS'(pnr_pkg::ROW_X_C1), COEF_BITS'(pnr_pkg::ROW_X_C0)};
  localparam logic [RW-1:0] ROW_Y_INIT = {COEF_BITS'(pnr_pkg::ROW_Y_C2),
    COEF_BITS'(pnr_pkg::ROW_Y_C1), COEF_BITS'(pnr_pkg::ROW_Y_C0)};
  localparam logic [RW-1:0] ROW_Z_INIT = {COEF_BITS'(pnr_pkg::ROW_Z_C2),
    COEF_BITS'(pnr_pkg::ROW_Z_C1), COEF_BITS'(pnr_pkg::ROW_Z_C0)};

  logic [RW-1:0] row_x;
  logic [RW-1:0] row_y;
  logic [RW-1:0] row_z;
  logic [RW-1:0] rows [NL];

  pnr_pkg::light_t        lv   [NL];
  logic signed [PW-1:0]   prod [NL][NL];
  logic signed [NW-1:0]   norm [NL];
  logic [LAT-1:0]         vld;
  logic                   en;
  pnr_pkg::level_t        red;
  pnr_pkg::level_t        green;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= ROW_X_INIT;
      row_y <= ROW_Y_INIT;
      row_z <= ROW_Z_INIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pnr_pkg::CFG_ROW_X: row_x <= cfg_data;
        pnr_pkg::CFG_ROW_Y: row_y <= cfg_data;
        pnr_pkg::CFG_ROW_Z: row_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar k = 0; k < NL; k++) begin : g_lv
    assign lv[k] = s_tdata[k*pnr_pkg::LIGHT_BITS +: pnr_pkg::LIGHT_BITS];
  end

  for (genvar r = 0; r < NL; r++) begin : g_row
    for (genvar k = 0; k < NL; k++) begin : g_mul
      logic signed [COEF_BITS-1:0] coef;
      assign coef = $signed(rows[r][k*COEF_BITS +: COEF_BITS]);
      always_ff @(posedge clk) begin
        if (en) begin
          prod[r][k] <= PW'(coef) * PW'($signed({1'b0, lv[k]}));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        norm[r] <= NW'(prod[r][0]) + NW'(prod[r][1]) + NW'(prod[r][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  pnr_ratio_div #(.NW(NW)) u_div_red (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (norm[0]),
    .den   (norm[2]),
    .level (red)
  );

  pnr_ratio_div #(.NW(NW)) u_div_green (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (norm[1]),
    .den   (norm[2]),
    .level (green)
  );

  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {green, red};

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == pnr_pkg::CFG_ROW_Z
    |=> row_z == $past(cfg_data))
    else $error("row_z write lost");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

### tb/tb_photometric_normal_ratio_pixel_top.sv
module tb_photometric_normal_ratio_pixel_top;

  localparam int COEF_BITS = 16;
  localparam int NUM_SETTINGS = 10;
  localparam int PIXELS_PER_SETTING = 198;
  localparam int HOLD_SETTING = 6;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SHOWN_ERRORS = 10;
  localparam logic [pnr_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef logic [3*COEF_BITS-1:0] coef_row_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef struct packed {
    pnr_pkg::light_t c;
    pnr_pkg::light_t b;
    pnr_pkg::light_t a;
  } pixel_t;
  typedef struct packed {
    pnr_pkg::level_t green;
    pnr_pkg::level_t red;
  } levels_t;

  localparam coef_t COEF_MAX = coef_t'((1 << (COEF_BITS-1)) - 1);
  localparam coef_t COEF_MIN = coef_t'(-(1 << (COEF_BITS-1)));

  // corner pixels, light a in the low byte
  localparam logic [23:0] CORNERS [14] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FFFF, 24'hFFFF00,
    24'hFF00FF, 24'h010101, 24'h204080, 24'h03C80A, 24'h030AC8, 24'hAA55AA, 24'h55AA55
  };

  class level_board;
    coef_row_t rows [3];
    levels_t expected_q [$];
    int failures;
    int pixels;
    int zero_z;
    int checked;

    function new();
      rows[0] = {coef_t'(pnr_pkg::ROW_X_C2), coef_t'(pnr_pkg::ROW_X_C1),
                 coef_t'(pnr_pkg::ROW_X_C0)};
      rows[1] = {coef_t'(pnr_pkg::ROW_Y_C2), coef_t'(pnr_pkg::ROW_Y_C1),
                 coef_t'(pnr_pkg::ROW_Y_C0)};
      rows[2] = {coef_t'(pnr_pkg::ROW_Z_C2), coef_t'(pnr_pkg::ROW_Z_C1),
                 coef_t'(pnr_pkg::ROW_Z_C0)};
      failures = 0;
      pixels = 0;
      zero_z = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [pnr_pkg::CFG_IDX_BITS-1:0] idx, coef_row_t v);
      if (idx inside {pnr_pkg::CFG_ROW_X, pnr_pkg::CFG_ROW_Y, pnr_pkg::CFG_ROW_Z})
        rows[idx] = v;
    endfunction

    function longint normal(coef_row_t row, pixel_t px);
      coef_t k0, k1, k2;
      k0 = row[0 +: COEF_BITS];
      k1 = row[COEF_BITS +: COEF_BITS];
      k2 = row[2*COEF_BITS +: COEF_BITS];
      return longint'(k0) * longint'(px.a) + longint'(k1) * longint'(px.b)
           + longint'(k2) * longint'(px.c);
    endfunction

    function pnr_pkg::level_t ratio(longint num, longint den);
      longint q;
      q = (num * 255) / den;
      if (q < 0)
        return '0;
      if (q > 255)
        return pnr_pkg::LEVEL_MAX;
      return pnr_pkg::level_t'(q);
    endfunction

    function void note_pixel(pixel_t px);
      longint nx, ny, nz;
      levels_t e;
      nx = normal(rows[0], px);
      ny = normal(rows[1], px);
      nz = normal(rows[2], px);
      if (nz == 0) begin
        e = '0;
        zero_z++;
      end else begin
        e.red = ratio(nx, nz);
        e.green = ratio(ny, nz);
      end
      expected_q.insert(expected_q.size(), e);
      pixels++;
    endfunction

    function void check_levels(levels_t got);
      levels_t e;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("result red %0d green %0d with no pixel pending", got.red, got.green);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.red !== e.red || got.green !== e.green) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("result %0d: red exp %0d got %0d, green exp %0d got %0d",
                   checked, e.red, got.red, e.green, got.green);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid;
  logic s_tready;
  logic [23:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [pnr_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [3*COEF_BITS-1:0] cfg_data;

  level_board board = new();
  bit tx_dense;
  bit rx_dense;
  bit long_hold_req;
  int settings;

  always #2 clk = ~clk;

  photometric_normal_ratio_pixel_top #(
    .COEF_BITS(COEF_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pnr_pkg::light_t random_light();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return pnr_pkg::light_t'($urandom);
  endfunction

  function automatic coef_row_t random_row(bit z_row);
    coef_row_t row;
    int r;
    for (int k = 0; k < 3; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        row[k*COEF_BITS +: COEF_BITS] = coef_t'($urandom);
      else if (r == 1) begin
        case ($urandom_range(0, 3))
          0: row[k*COEF_BITS +: COEF_BITS] = COEF_MAX;
          1: row[k*COEF_BITS +: COEF_BITS] = COEF_MIN;
          2: row[k*COEF_BITS +: COEF_BITS] = '0;
          default: row[k*COEF_BITS +: COEF_BITS] = '1;
        endcase
      end else if (z_row)
        row[k*COEF_BITS +: COEF_BITS] = coef_t'($urandom_range(1, 300));
      else
        row[k*COEF_BITS +: COEF_BITS] = coef_t'(int'($urandom_range(0, 128)) - 64);
    end
    return row;
  endfunction

  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = tx_dense ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    board.note_pixel(px);
  endtask

  task automatic load_rows(input coef_row_t rx, input coef_row_t ry, input coef_row_t rz,
                           input bit poke_unused);
    logic [pnr_pkg::CFG_IDX_BITS-1:0] idx [4];
    coef_row_t val [4];
    int first;
    idx = '{CFG_UNUSED, pnr_pkg::CFG_ROW_X, pnr_pkg::CFG_ROW_Y, pnr_pkg::CFG_ROW_Z};
    val = '{coef_row_t'({$urandom, $urandom}), rx, ry, rz};
    first = poke_unused ? 0 : 1;
    for (int i = first; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && board.pending() != 0; i++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    m_tready = 1'b0;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        board.check_levels(levels_t'(m_tdata));
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !rx_dense)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    pixel_t px;
    int n_corners;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_dense = 1'b0;
    rx_dense = 1'b0;
    long_hold_req = 1'b0;
    settings = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        wait_results();
        case (p)
          1: load_rows({3{COEF_MAX}}, {3{COEF_MIN}}, {3{COEF_MAX}}, 1'b1);
          2: load_rows({3{COEF_MIN}}, {3{COEF_MAX}}, {3{COEF_MIN}}, 1'b0);
          3: load_rows(random_row(1'b0), random_row(1'b0), '0, 1'b1);
          4: load_rows(random_row(1'b0), random_row(1'b0),
                       {coef_t'(0), coef_t'(-1), coef_t'(1)}, 1'b0);
          default: load_rows(random_row(1'b0), random_row(1'b0), random_row(1'b1),
                             $urandom_range(0, 1));
        endcase
      end
      tx_dense = (p == 4) || (p == HOLD_SETTING);
      rx_dense = (p == 4);

      n_corners = (p == 0) ? 14 : ((p <= 4) ? 2 : 0);
      for (int i = 0; i < n_corners; i++)
        send_pixel(CORNERS[i]);

      for (int i = 0; i < PIXELS_PER_SETTING; i++) begin
        if (p == HOLD_SETTING && i == 40)
          long_hold_req = 1'b1;
        px.a = random_light();
        px.b = random_light();
        px.c = random_light();
        if (p == 4 && $urandom_range(0, 2) == 0)
          px.b = px.a;
        send_pixel(px);
      end
    end

    wait_results();
    $display("covered %0d pixels across %0d coefficient settings, %0d with zero z component",
             board.pixels, settings, board.zero_z);
    $display("%0d results checked, %0d still pending, %0d errors",
             board.checked, board.pending(), board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
